// File: hw/rtl/hbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared constants, node record layout and codes of the Huffman stream decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int MAX_CODE_LEN  = 16;
    localparam int NODE_COUNT    = 512;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int NODE_CNT_W    = $clog2(NODE_COUNT + 1);
    localparam int CODE_W        = 16;
    localparam int CODE_IDX_W    = $clog2(CODE_W);
    localparam int LEN_W         = 5;
    localparam int SYM_W         = 8;
    localparam int BYTE_W        = 8;
    localparam int BIT_CNT_W     = $clog2(BYTE_W) + 1;
    localparam int TOTAL_W       = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SYMBOL   = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // One tree node: child links (0 = none), leaf flag, symbol
    typedef struct packed {
        logic [NODE_W-1:0] kid0;
        logic [NODE_W-1:0] kid1;
        logic              leaf;
        logic [SYM_W-1:0]  sym;
    } node_rec_t;

    localparam int REC_W = $bits(node_rec_t);

endpackage

// File: hw/rtl/huffman_bit_stream_decoder_core.sv
`timescale 1ns / 1ps
// Decode: each coded bit runs the check, step and next-node states, after a current-node read
//   when no record is held; a missing child ends at the step; output stalls hold the walk.
// Load: accept, root read, a node read or new-node step per code bit, leaf write, done.
// One item at a time; results leave through an output register.
// Reset (synchronous, active low) and the clear command zero the root in the init state.
// Reset sets total_bits to 0.
// ----------------------------------------------------------------------------
// huffman_bit_stream_decoder_core
// Code-tree builder and bit-serial Huffman stream walker over a node RAM.
// ----------------------------------------------------------------------------
module huffman_bit_stream_decoder_core
    import hbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TOTAL_W-1:0]   cfg_total_bits,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [LEN_W-1:0]     s_code_length,
    input  logic [CODE_W-1:0]    s_code_bits,
    input  logic [BYTE_W-1:0]    s_data_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SYM_W-1:0]     m_out_symbol,
    output logic [STATUS_W-1:0]  m_status,
    output logic                 m_last
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_LRD, S_LEV, S_LNEW, S_DCHK, S_DCUR, S_DSTEP, S_DNXT, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [TOTAL_W-1:0]     total_bits_reg;
    logic [TOTAL_W-1:0]     bits_used_reg;
    logic [NODE_CNT_W-1:0]  nodes_used_reg;
    logic [NODE_W-1:0]      cur_node_reg;
    logic                   cur_vld_reg;
    logic [NODE_W-1:0]      node_reg;
    logic [NODE_W-1:0]      next_reg;
    node_rec_t              rec_reg;
    logic                   rec_fresh_reg;
    logic [LEN_W-1:0]       i_reg;
    logic [CODE_W-1:0]      code_reg;
    logic [SYM_W-1:0]       sym_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic [BIT_CNT_W-1:0]   bcnt_reg;

    logic                   pend_vld_reg;
    logic [SYM_W-1:0]       pend_sym_reg;
    status_t                pend_status_reg;
    logic                   m_valid_reg;
    logic [SYM_W-1:0]       m_sym_reg;
    status_t                m_status_reg;
    logic                   m_last_reg;

    logic                   ram_wr_en;
    logic [NODE_W-1:0]      ram_wr_addr;
    node_rec_t              ram_wr_data;
    logic [NODE_W-1:0]      ram_rd_addr;
    logic [REC_W-1:0]       ram_rd_raw;
    node_rec_t              ram_rd_data;

    node_rec_t              rec_use;
    node_rec_t              link_rec;
    logic [LEN_W-1:0]       i_m1;
    logic                   load_bit;
    logic [NODE_W-1:0]      load_next;
    logic                   store_full;
    logic                   dec_bit;
    logic [NODE_W-1:0]      dec_next;
    logic                   can_push;
    logic                   res_fire;
    logic [SYM_W-1:0]       res_sym;
    status_t                res_status;
    logic                   s_beat;
    logic                   out_push;

    assign ram_rd_data = node_rec_t'(ram_rd_raw);

    hbd_ram #(
        .WIDTH (REC_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign s_beat       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_sym_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

    // Record of the load walk's node: fresh from RAM or held (new nodes are known zero)
    assign rec_use    = rec_fresh_reg ? ram_rd_data : rec_reg;
    assign i_m1       = i_reg - LEN_W'(1);
    assign load_bit   = code_reg[i_m1[CODE_IDX_W-1:0]];
    assign load_next  = load_bit ? rec_use.kid1 : rec_use.kid0;
    assign store_full = (nodes_used_reg >= NODE_CNT_W'(NODE_COUNT));
    assign dec_bit    = byte_reg[~bcnt_reg[BIT_CNT_W-2:0]];
    assign dec_next   = dec_bit ? rec_reg.kid1 : rec_reg.kid0;
    assign can_push   = !pend_vld_reg || !m_valid_reg || m_ready;
    // Held result moves into the output register this cycle
    assign out_push   = pend_vld_reg && can_push && (res_fire || state_reg == S_DONE);

    always_comb begin
        link_rec = rec_use;
        if (load_bit) begin
            link_rec.kid1 = nodes_used_reg[NODE_W-1:0];
        end else begin
            link_rec.kid0 = nodes_used_reg[NODE_W-1:0];
        end
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = node_reg;
        ram_wr_data = '0;
        case (state_reg)
            S_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
            end
            S_LEV: begin
                if (i_reg == '0) begin
                    ram_wr_en        = 1'b1;
                    ram_wr_data      = rec_use;
                    ram_wr_data.leaf = 1'b1;
                    ram_wr_data.sym  = sym_reg;
                end else if (load_next == '0 && !store_full) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = link_rec;
                end
            end
            S_LNEW: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = nodes_used_reg[NODE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            S_DCHK:  ram_rd_addr = cur_node_reg;
            S_DSTEP: ram_rd_addr = dec_next;
            S_DNXT:  ram_rd_addr = next_reg;
            default: ram_rd_addr = node_reg;
        endcase
    end

    always_comb begin
        res_fire   = 1'b0;
        res_sym    = '0;
        res_status = ST_SYMBOL;
        case (state_reg)
            S_LEV: begin
                if (i_reg != '0 && load_next == '0 && store_full) begin
                    res_fire   = 1'b1;
                    res_sym    = sym_reg;
                    res_status = ST_FULL;
                end
            end
            S_DSTEP: begin
                if (dec_next == '0 && can_push) begin
                    res_fire   = 1'b1;
                    res_status = ST_BAD_CODE;
                end
            end
            S_DNXT: begin
                if (ram_rd_data.kid0 == '0 && ram_rd_data.kid1 == '0 && can_push) begin
                    res_fire = 1'b1;
                    if (ram_rd_data.leaf) begin
                        res_sym = ram_rd_data.sym;
                    end else begin
                        res_status = ST_BAD_CODE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            total_bits_reg <= '0;
            bits_used_reg  <= '0;
            nodes_used_reg <= NODE_CNT_W'(1);
            cur_node_reg   <= '0;
            cur_vld_reg    <= 1'b0;
            rec_fresh_reg  <= 1'b0;
            bcnt_reg       <= '0;
            pend_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                total_bits_reg <= cfg_total_bits;
            end
            if (m_valid_reg && m_ready && !out_push) begin
                m_valid_reg <= 1'b0;
            end
            // A new result pushes the held one out; last is only known at the end
            if (res_fire) begin
                if (pend_vld_reg) begin
                    m_valid_reg  <= 1'b1;
                    m_sym_reg    <= pend_sym_reg;
                    m_status_reg <= pend_status_reg;
                    m_last_reg   <= 1'b0;
                end
                pend_vld_reg    <= 1'b1;
                pend_sym_reg    <= res_sym;
                pend_status_reg <= res_status;
            end

            case (state_reg)
                S_INIT: begin
                    state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_beat) begin
                        code_reg      <= s_code_bits;
                        sym_reg       <= s_symbol;
                        byte_reg      <= s_data_byte;
                        i_reg         <= s_code_length;
                        node_reg      <= '0;
                        bcnt_reg      <= '0;
                        cur_vld_reg   <= 1'b0;
                        rec_fresh_reg <= 1'b1;
                        case (cmd_t'(s_command))
                            CMD_LOAD: begin
                                if (s_code_length == '0 ||
                                    s_code_length > LEN_W'(MAX_CODE_LEN)) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_LRD;
                                end
                            end
                            CMD_DECODE: begin
                                state_reg <= S_DCHK;
                            end
                            CMD_CLEAR: begin
                                nodes_used_reg <= NODE_CNT_W'(1);
                                cur_node_reg   <= '0;
                                bits_used_reg  <= '0;
                                state_reg      <= S_INIT;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_LRD: begin
                    rec_fresh_reg <= 1'b1;
                    state_reg     <= S_LEV;
                end
                S_LEV: begin
                    if (i_reg == '0) begin
                        state_reg <= S_DONE;
                    end else if (load_next != '0) begin
                        node_reg  <= load_next;
                        i_reg     <= i_m1;
                        state_reg <= S_LRD;
                    end else if (store_full) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_LNEW;
                    end
                end
                S_LNEW: begin
                    node_reg       <= nodes_used_reg[NODE_W-1:0];
                    nodes_used_reg <= nodes_used_reg + NODE_CNT_W'(1);
                    rec_reg        <= '0;
                    rec_fresh_reg  <= 1'b0;
                    i_reg          <= i_m1;
                    state_reg      <= S_LEV;
                end
                S_DCHK: begin
                    if (bits_used_reg >= total_bits_reg || bcnt_reg[BIT_CNT_W-1]) begin
                        state_reg <= S_DONE;
                    end else if (cur_vld_reg) begin
                        state_reg <= S_DSTEP;
                    end else begin
                        state_reg <= S_DCUR;
                    end
                end
                S_DCUR: begin
                    rec_reg     <= ram_rd_data;
                    cur_vld_reg <= 1'b1;
                    state_reg   <= S_DSTEP;
                end
                S_DSTEP: begin
                    if (dec_next != '0) begin
                        next_reg  <= dec_next;
                        state_reg <= S_DNXT;
                    end else if (can_push) begin
                        cur_node_reg  <= '0;
                        cur_vld_reg   <= 1'b0;
                        bits_used_reg <= bits_used_reg + TOTAL_W'(1);
                        bcnt_reg      <= bcnt_reg + BIT_CNT_W'(1);
                        state_reg     <= S_DCHK;
                    end
                end
                S_DNXT: begin
                    if (ram_rd_data.kid0 == '0 && ram_rd_data.kid1 == '0) begin
                        if (can_push) begin
                            cur_node_reg  <= '0;
                            cur_vld_reg   <= 1'b0;
                            bits_used_reg <= bits_used_reg + TOTAL_W'(1);
                            bcnt_reg      <= bcnt_reg + BIT_CNT_W'(1);
                            state_reg     <= S_DCHK;
                        end
                    end else begin
                        cur_node_reg  <= next_reg;
                        rec_reg       <= ram_rd_data;
                        cur_vld_reg   <= 1'b1;
                        bits_used_reg <= bits_used_reg + TOTAL_W'(1);
                        bcnt_reg      <= bcnt_reg + BIT_CNT_W'(1);
                        state_reg     <= S_DCHK;
                    end
                end
                S_DONE: begin
                    if (!pend_vld_reg) begin
                        state_reg <= S_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_sym_reg    <= pend_sym_reg;
                        m_status_reg <= pend_status_reg;
                        m_last_reg   <= 1'b1;
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_INIT;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // No result may be held back while a new item can come in
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_vld_reg)
        else $error("held result while idle");

    a_nodes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg >= NODE_CNT_W'(1) && nodes_used_reg <= NODE_CNT_W'(NODE_COUNT))
        else $error("node count out of range");

    a_bit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= BIT_CNT_W'(BYTE_W))
        else $error("bit counter overran the byte");

    // A result is only produced with room to move the held one on
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_fire && pend_vld_reg) |-> (!m_valid_reg || m_ready))
        else $error("result push over a stalled output");

    a_new_node_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LNEW) |-> !store_full)
        else $error("node created in a full store");
`endif

endmodule

// File: hw/rtl/hbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman bit-stream decoder core. A bit-accurate
// copy of the code tree predicts every result beat. Directed loads and decodes
// come first, then random code sets and data streams under several
// total_bits settings and backpressure patterns.
// ----------------------------------------------------------------------------
module tb;
    import hbd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int FILL_LOADS    = 50;
    localparam int FILL_PROBES   = 8;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] data;
    } stream_item_t;

    typedef struct {
        logic [SYM_W-1:0] sym;
        status_t          status;
        logic             last;
    } sym_result_t;

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [TOTAL_W-1:0]  cfg_total_bits = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command      = '0;
    logic [SYM_W-1:0]    s_symbol       = '0;
    logic [LEN_W-1:0]    s_code_length  = '0;
    logic [CODE_W-1:0]   s_code_bits    = '0;
    logic [BYTE_W-1:0]   s_data_byte    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [SYM_W-1:0]    m_out_symbol;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    huffman_bit_stream_decoder_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_total_bits (cfg_total_bits),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_symbol       (s_symbol),
        .s_code_length  (s_code_length),
        .s_code_bits    (s_code_bits),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    stream_item_t cmd_q[$];
    sym_result_t  decoded_q[$];
    stream_item_t cur;
    sym_result_t  want;
    logic         s_fire = 1'b0;
    int           s_idle_pct = 9;
    int           m_idle_pct = 80;
    int           err_cnt = 0;
    int           gen_cnt = 0;
    int           cycle_cnt = 0;

    // tree copy
    logic [NODE_W-1:0]     kid0_m [NODE_COUNT];
    logic [NODE_W-1:0]     kid1_m [NODE_COUNT];
    logic                  leaf_m [NODE_COUNT];
    logic [SYM_W-1:0]      sym_m  [NODE_COUNT];
    logic [NODE_CNT_W-1:0] nodes_alloc;
    logic [NODE_W-1:0]     walk_node;
    logic [TOTAL_W-1:0]    bits_seen;
    logic [TOTAL_W-1:0]    total_bits_reg;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic tree_clear();
        int n;
        for (n = 0; n < NODE_COUNT; n++) begin
            kid0_m[n] = '0;
            kid1_m[n] = '0;
            leaf_m[n] = 1'b0;
            sym_m[n]  = '0;
        end
        nodes_alloc = NODE_CNT_W'(1);
        walk_node   = '0;
        bits_seen   = '0;
    endtask

    task automatic tree_load(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                             input logic [CODE_W-1:0] code);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] nxt;
        logic              b;
        int                i;
        node = '0;
        if (len == 0 || len > MAX_CODE_LEN)
            return;
        for (i = int'(len); i > 0; i--) begin
            b   = code[i-1];
            nxt = b ? kid1_m[node] : kid0_m[node];
            if (nxt == 0) begin
                if (nodes_alloc >= NODE_COUNT) begin
                    // partial path stays in the tree
                    decoded_q.push_back('{sym, ST_FULL, 1'b1});
                    return;
                end
                nxt = nodes_alloc[NODE_W-1:0];
                nodes_alloc = nodes_alloc + NODE_CNT_W'(1);
                if (b)
                    kid1_m[node] = nxt;
                else
                    kid0_m[node] = nxt;
            end
            node = nxt;
        end
        sym_m[node]  = sym;
        leaf_m[node] = 1'b1;
    endtask

    task automatic tree_walk_byte(input logic [BYTE_W-1:0] data);
        sym_result_t       got[$];
        logic [NODE_W-1:0] nxt;
        int                i;
        for (i = BYTE_W - 1; i >= 0; i--) begin
            if (bits_seen >= total_bits_reg)
                break;
            bits_seen = bits_seen + TOTAL_W'(1);
            nxt = data[i] ? kid1_m[walk_node] : kid0_m[walk_node];
            if (nxt == 0) begin
                got.push_back('{'0, ST_BAD_CODE, 1'b0});
                walk_node = '0;
                continue;
            end
            if (kid0_m[nxt] == 0 && kid1_m[nxt] == 0) begin
                if (leaf_m[nxt])
                    got.push_back('{sym_m[nxt], ST_SYMBOL, 1'b0});
                else
                    got.push_back('{'0, ST_BAD_CODE, 1'b0});
                walk_node = '0;
            end else begin
                // symbol on an inner node is ignored
                walk_node = nxt;
            end
        end
        if (got.size() > 0)
            got[got.size()-1].last = 1'b1;
        foreach (got[k])
            decoded_q.push_back(got[k]);
    endtask

    // prediction and checking, sampled at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            tree_clear();
            total_bits_reg = '0;
            s_fire <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result beat: out_symbol %0h status %0d last %0b",
                           m_out_symbol, m_status, m_last);
                    err_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_symbol !== want.sym) begin
                        $error("out_symbol: expected %0h, got %0h", want.sym, m_out_symbol);
                        err_cnt++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        err_cnt++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_last);
                        err_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                total_bits_reg = cfg_total_bits;
            if (s_valid && s_ready) begin
                if (s_command == CMD_LOAD)
                    tree_load(s_symbol, s_code_length, s_code_bits);
                else if (s_command == CMD_DECODE)
                    tree_walk_byte(s_data_byte);
                else if (s_command == CMD_CLEAR)
                    tree_clear();
            end
            s_fire <= s_valid && s_ready;
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (!s_valid || s_fire) begin
            if (aresetn && cmd_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                cur = cmd_q.pop_front();
                s_valid       <= 1'b1;
                s_command     <= cur.cmd;
                s_symbol      <= cur.sym;
                s_code_length <= cur.len;
                s_code_bits   <= cur.code;
                s_data_byte   <= cur.data;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** huffman_bit_stream_decoder_core: FAILED **");
            $finish;
        end
    end

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                              input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                              input logic [BYTE_W-1:0] data);
        cmd_q.push_back('{cmd, sym, len, code, data});
        gen_cnt++;
    endtask

    task automatic put_load(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                            input logic [CODE_W-1:0] code);
        queue_item(CMD_LOAD, sym, len, code, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic put_decode(input logic [BYTE_W-1:0] data);
        queue_item(CMD_DECODE, SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 31)),
                   CODE_W'($urandom_range(0, 65535)), data);
    endtask

    task automatic put_clear();
        queue_item(CMD_CLEAR, SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 31)),
                   CODE_W'($urandom_range(0, 65535)), BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (cmd_q.size() != 0 || s_valid || decoded_q.size() != 0);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] value);
        wait_drained();
        // clears and loads into a non-full store give no beat, so let the core finish them
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_total_bits <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // fill the node store with long random codes, then walk the last ones
    task automatic gen_fill();
        logic [CODE_W-1:0] tail[$];
        int                k;
        put_clear();
        for (k = 0; k < FILL_LOADS; k++) begin
            tail.push_back(CODE_W'($urandom_range(0, 65535)));
            put_load(SYM_W'($urandom_range(0, 255)), LEN_W'(MAX_CODE_LEN), tail[k]);
        end
        for (k = FILL_LOADS - FILL_PROBES; k < FILL_LOADS; k++) begin
            put_decode(tail[k][15:8]);
            put_decode(tail[k][7:0]);
        end
    endtask

    // complete prefix code, loaded in random order with some loads dropped, then an encoded stream
    task automatic gen_wellformed();
        logic [CODE_W-1:0] cw[$];
        int                cl[$];
        logic [SYM_W-1:0]  cs[$];
        int                ord[$];
        bit                bitq[$];
        logic [CODE_W-1:0] c;
        logic [BYTE_W-1:0] b;
        int                n, k, j, idx, tries;
        cw.push_back('0);
        cl.push_back(0);
        n = $urandom_range(2, 17);
        for (k = 1; k < n; k++) begin
            // leaning on the newest leaf grows deep chains
            idx = ($urandom_range(0, 9) < 6) ? cw.size() - 1 : $urandom_range(0, cw.size() - 1);
            tries = 0;
            while (cl[idx] >= MAX_CODE_LEN && tries < 8) begin
                idx = $urandom_range(0, cw.size() - 1);
                tries++;
            end
            if (cl[idx] < MAX_CODE_LEN) begin
                c = cw[idx];
                cw[idx] = c << 1;
                cl[idx] = cl[idx] + 1;
                cw.push_back((c << 1) | 1'b1);
                cl.push_back(cl[idx]);
            end
        end
        foreach (cw[i]) begin
            cs.push_back(SYM_W'($urandom_range(0, 255)));
            ord.push_back(i);
        end
        if ($urandom_range(0, 9) != 0)
            put_clear();
        while (ord.size() != 0) begin
            idx = $urandom_range(0, ord.size() - 1);
            if ($urandom_range(0, 99) >= 8)
                put_load(cs[ord[idx]], LEN_W'(cl[ord[idx]]), cw[ord[idx]]);
            ord.delete(idx);
        end
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            idx = $urandom_range(0, cw.size() - 1);
            for (j = cl[idx] - 1; j >= 0; j--)
                bitq.push_back(cw[idx][j]);
        end
        while (bitq.size() % BYTE_W != 0)
            bitq.push_back(1'($urandom_range(0, 1)));
        while (bitq.size() != 0) begin
            for (j = 0; j < BYTE_W; j++)
                b = {b[BYTE_W-2:0], bitq.pop_front()};
            if ($urandom_range(0, 99) < 5)
                b = b ^ (8'd1 << $urandom_range(0, 7));
            put_decode(b);
        end
    endtask

    task automatic gen_noise();
        int k;
        int n;
        logic [LEN_W-1:0] len;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
            len = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(1, MAX_CODE_LEN))
                                              : LEN_W'($urandom_range(0, 31));
            queue_item(CMD_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)), len,
                       CODE_W'($urandom_range(0, 65535)), BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic gen_items(input int target, input bit with_fill);
        int start;
        start = gen_cnt;
        if (with_fill)
            gen_fill();
        while (gen_cnt - start < target) begin
            if ($urandom_range(0, 99) < 75)
                gen_wellformed();
            else
                gen_noise();
        end
    endtask

    // half the items, wait for every beat, then the rest
    task automatic run_random(input int target, input bit with_fill);
        gen_items(target / 2, with_fill);
        wait_drained();
        gen_items(target - target / 2, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_total('1);
        put_load(8'h41, 5'd1, 16'h0000);       // 0
        put_load(8'h42, 5'd2, 16'h0002);       // 10
        put_load(8'hFF, 5'd16, 16'hFFFF);
        put_load(8'h00, 5'd16, 16'hC000);
        put_load(8'h99, 5'd0, 16'hFFFF);       // zero length: ignored
        put_load(8'h98, 5'd31, 16'h0000);      // too long: ignored
        queue_item(CMD_RESERVED, 8'hFF, 5'd31, 16'hFFFF, 8'hFF);
        put_decode(8'h00);
        put_decode(8'hAA);
        put_decode(8'hFF);                     // stops mid-tree
        put_load(8'h77, 5'd4, 16'h000D);       // load during a walk
        put_decode(8'hFF);
        put_decode(8'hC8);                     // missing child
        put_load(8'h55, 5'd3, 16'h0007);       // symbol on an inner node
        put_decode(8'hE0);
        put_clear();
        put_decode(8'h00);                     // empty tree

        write_total('0);
        put_clear();
        put_load(8'h5A, 5'd1, 16'h0000);
        put_decode(8'h00);
        put_decode(8'hFF);
        write_total(32'd1);
        put_decode(8'h00);
        put_decode(8'h55);

        write_total('1);
        run_random(110, 1'b1);

        write_total($urandom_range(20, 60));
        s_idle_pct = 80;
        m_idle_pct = 9;
        run_random(100, 1'b0);

        write_total(32'h8000_0000 | $urandom());
        s_idle_pct = 0;
        m_idle_pct = 0;
        run_random(110, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("** huffman_bit_stream_decoder_core: PASSED **");
        else
            $display("** huffman_bit_stream_decoder_core: FAILED **");
        $finish;
    end

endmodule
